// ----- rtl/tcu_pkg.sv -----
package tcu_pkg;

  localparam int unsigned ANGLE_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned TOL_W    = 31;
  localparam int unsigned COS_W    = 48;
  localparam int unsigned MAG_W    = 47;
  localparam int unsigned XSQ_W    = 63;
  localparam int unsigned OP_W     = 32;
  localparam int unsigned PROD_W   = 2 * OP_W;
  localparam int unsigned ACC_W    = 110;
  localparam int unsigned K_W      = 12;
  localparam int unsigned KOP_W    = 7;
  localparam int unsigned DIV_STEP = 8;
  localparam int unsigned DIV_CYC  = 6;
  localparam int unsigned DQ_W     = DIV_STEP * DIV_CYC;
  localparam int unsigned CNT_W    = 3;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [COS_W-1:0] SUM_MAX = {1'b0, {(COS_W-1){1'b1}}};
  localparam logic [COS_W-1:0] SUM_MIN = {1'b1, {(COS_W-1){1'b0}}};

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(4);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_CYC - 1);

  typedef enum logic {
    CMD_FIXED = 1'b0,
    CMD_TOL   = 1'b1
  } tcu_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ADD,
    ST_MUL,
    ST_DCHK,
    ST_DIV,
    ST_DONE
  } tcu_state_e;

  typedef struct packed {
    logic                       command;
    logic signed [ANGLE_W-1:0]  angle;
    logic        [COUNT_W-1:0]  term_count;
    logic        [TOL_W-1:0]    tolerance;
  } tcu_req_t;

  typedef struct packed {
    logic signed [COS_W-1:0]    cosine;
    logic        [COUNT_W-1:0]  terms_used;
    logic                       not_converged;
    logic                       saturated;
  } tcu_rsp_t;

endpackage

// ----- rtl/taylor_cosine_unit.sv -----
// Channel  | Ports                    | Handshake
// ---------+--------------------------+-------------------------------------
// request  | start, busy, req_i       | taken at a clock edge with start & !busy
// result   | done_o, rsp_o            | valid for the single cycle done_o is high
//
// One shared 32x32 multiplier forms the angle square, then each new term as
// four partial products; an 8-bit-per-cycle restoring divider scales it.
// A request with zero summed terms goes from the square straight to done_o; a
// term clipped before the divide skips the divide steps. busy stays high
// until the done_o cycle ends. Reset clears the sequencer; the result side
// cannot stall, so done_o is never held.
module taylor_cosine_unit
  import tcu_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 16,
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  tcu_req_t req_i,
  output logic     done_o,
  output tcu_rsp_t rsp_o
);

  localparam int unsigned I_W = $clog2(MAX_TERMS + 1);
  localparam logic [MAG_W-1:0] INIT_MAG = MAG_W'(1) << FRAC_BITS;

  tcu_state_e state_q, state_d;

  logic               mode_q, mode_d;
  logic [OP_W-1:0]    ax_q, ax_d;
  logic [TOL_W-1:0]   tol_q, tol_d;
  logic [I_W-1:0]     limit_q, limit_d;
  logic [I_W-1:0]     i_q, i_d;
  logic [XSQ_W-1:0]   xsq_q, xsq_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [COS_W-1:0]   sum_q, sum_d;
  logic               sat_q, sat_d;
  logic               nconv_q, nconv_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [K_W-1:0]     rem_q, rem_d;
  logic [DQ_W-1:0]    dq_q, dq_d;

  logic [OP_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [OP_W-1:0]    ax_in;
  logic [COS_W:0]     sum_x;
  logic [KOP_W-1:0]   k_a, k_b;
  logic [ACC_W-1:0]   v_w, v_hi;
  logic [K_W-1:0]     div_rem;
  logic [DQ_W-1:0]    div_dq;
  logic [1:0]         part;

  assign mul_p = mul_a * mul_b;
  assign ax_in = req_i.angle[ANGLE_W-1] ? (~req_i.angle + OP_W'(1)) : req_i.angle;
  assign k_a   = KOP_W'({i_q, 1'b1});
  assign k_b   = KOP_W'({i_q, 1'b0}) + KOP_W'(2);
  assign v_w   = acc_q >> (2 * FRAC_BITS);
  assign v_hi  = v_w >> DQ_W;
  assign part  = 2'(cnt_q - CNT_W'(1));

  always_comb begin
    logic [K_W:0]    t;
    logic [K_W-1:0]  r;
    logic [DQ_W-1:0] d;
    r = rem_q;
    d = dq_q;
    for (int j = 0; j < DIV_STEP; j++) begin
      t = {r, d[DQ_W-1]};
      d = {d[DQ_W-2:0], 1'b0};
      if (t >= {1'b0, k_q}) begin
        t    = t - {1'b0, k_q};
        d[0] = 1'b1;
      end
      r = t[K_W-1:0];
    end
    div_rem = r;
    div_dq  = d;
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    ax_d    = ax_q;
    tol_d   = tol_q;
    limit_d = limit_q;
    i_d     = i_q;
    xsq_d   = xsq_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    sum_d   = sum_q;
    sat_d   = sat_q;
    nconv_d = nconv_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    dq_d    = dq_q;
    mul_a   = ax_q;
    mul_b   = ax_q;
    sum_x   = '0;
    busy    = (state_q != ST_IDLE);
    done_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          mode_d  = req_i.command;
          ax_d    = ax_in;
          tol_d   = req_i.tolerance;
          if (req_i.command == CMD_TOL || 32'(req_i.term_count) > MAX_TERMS) begin
            limit_d = I_W'(MAX_TERMS);
          end else begin
            limit_d = I_W'(req_i.term_count);
          end
          i_d     = '0;
          mag_d   = INIT_MAG;
          neg_d   = 1'b0;
          sum_d   = '0;
          sat_d   = 1'b0;
          nconv_d = 1'b0;
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        xsq_d   = mul_p[XSQ_W-1:0];
        state_d = (limit_q == '0) ? ST_DONE : ST_ADD;
      end
      ST_ADD: begin
        if (neg_q) begin
          sum_x = {sum_q[COS_W-1], sum_q} - (COS_W+1)'(mag_q);
        end else begin
          sum_x = {sum_q[COS_W-1], sum_q} + (COS_W+1)'(mag_q);
        end
        if (sum_x[COS_W] != sum_x[COS_W-1]) begin
          sum_d = sum_x[COS_W] ? SUM_MIN : SUM_MAX;
          sat_d = 1'b1;
        end else begin
          sum_d = sum_x[COS_W-1:0];
        end
        k_d   = K_W'(k_a * k_b);
        i_d   = i_q + I_W'(1);
        cnt_d = '0;
        acc_d = '0;
        priority if (mode_q == CMD_TOL && mag_q <= MAG_W'(tol_q)) begin
          state_d = ST_DONE;
        end else if (i_d == limit_q) begin
          nconv_d = (mode_q == CMD_TOL);
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_a  = cnt_q[1] ? OP_W'(mag_q[MAG_W-1:OP_W]) : mag_q[OP_W-1:0];
        mul_b  = cnt_q[0] ? OP_W'(xsq_q[XSQ_W-1:OP_W]) : xsq_q[OP_W-1:0];
        prod_d = mul_p;
        if (cnt_q != '0) begin
          unique case (part)
            2'd0:        acc_d = acc_q + ACC_W'(prod_q);
            2'd1, 2'd2:  acc_d = acc_q + (ACC_W'(prod_q) << OP_W);
            default:     acc_d = acc_q + (ACC_W'(prod_q) << (2 * OP_W));
          endcase
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == MUL_LAST) begin
          state_d = ST_DCHK;
        end
      end
      ST_DCHK: begin
        cnt_d = '0;
        if (v_hi >= ACC_W'(k_q)) begin
          mag_d   = MAG_MAX;
          sat_d   = 1'b1;
          neg_d   = ~neg_q;
          state_d = ST_ADD;
        end else begin
          rem_d   = K_W'(v_hi);
          dq_d    = v_w[DQ_W-1:0];
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = div_rem;
        dq_d  = div_dq;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          if (div_dq[DQ_W-1:MAG_W] != '0) begin
            mag_d = MAG_MAX;
            sat_d = 1'b1;
          end else begin
            mag_d = div_dq[MAG_W-1:0];
          end
          neg_d   = ~neg_q;
          state_d = ST_ADD;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o.cosine        = sum_q;
  assign rsp_o.terms_used    = COUNT_W'(i_q);
  assign rsp_o.not_converged = nconv_q;
  assign rsp_o.saturated     = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      cnt_q   <= '0;
      limit_q <= '0;
      mode_q  <= 1'b0;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
      nconv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
      limit_q <= limit_d;
      mode_q  <= mode_d;
      neg_q   <= neg_d;
      sat_q   <= sat_d;
      nconv_q <= nconv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    tol_q  <= tol_d;
    xsq_q  <= xsq_d;
    mag_q  <= mag_d;
    sum_q  <= sum_d;
    k_q    <= k_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    dq_q   <= dq_d;
  end

endmodule

// ----- dv/taylor_cosine_unit_test.sv -----
`timescale 1ns / 100ps

module taylor_cosine_unit_test;
  import tcu_pkg::*;

  localparam int unsigned MAX_TERMS  = 16;
  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned N_RANDOM   = 1500;
  localparam int unsigned CYCLE_CAP  = 1500000;
  localparam int unsigned TAIL_WAIT  = 16;
  localparam longint      SUM_HI     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      SUM_LO     = -SUM_HI - 1;
  localparam logic [63:0] TERM_LIMIT = 64'h0000_7FFF_FFFF_FFFF;

  class cosine_scoreboard;
    tcu_rsp_t    expected_q[$];
    int unsigned fault_count = 0;

    function tcu_rsp_t cosine_of(tcu_req_t r);
      logic [31:0]  raw;
      logic [63:0]  ax;
      logic [63:0]  xsq;
      logic [63:0]  mag;
      logic [127:0] prod;
      logic [127:0] q;
      longint       sum;
      bit           neg;
      bit           sat;
      bit           nconv;
      bit           tol_mode;
      int unsigned  lim;
      int unsigned  used;
      int unsigned  k;
      tcu_rsp_t     o;
      raw      = r.angle;
      ax       = raw[31] ? (64'h1_0000_0000 - {32'b0, raw}) : {32'b0, raw};
      xsq      = ax * ax;
      mag      = 64'd1 << FRAC_BITS;
      sum      = 0;
      neg      = 1'b0;
      sat      = 1'b0;
      nconv    = 1'b0;
      used     = 0;
      tol_mode = (r.command == CMD_TOL);
      if (tol_mode) lim = MAX_TERMS;
      else lim = (r.term_count > MAX_TERMS) ? MAX_TERMS : r.term_count;
      for (int unsigned i = 0; i < lim; i++) begin
        if (neg) begin
          sum = sum - longint'(mag);
          if (sum < SUM_LO) begin
            sum = SUM_LO;
            sat = 1'b1;
          end
        end else begin
          sum = sum + longint'(mag);
          if (sum > SUM_HI) begin
            sum = SUM_HI;
            sat = 1'b1;
          end
        end
        used = i + 1;
        if (tol_mode && mag <= {33'b0, r.tolerance}) break;
        if (tol_mode && used == lim) begin
          nconv = 1'b1;
          break;
        end
        k    = (2 * i + 1) * (2 * i + 2);
        prod = {64'b0, mag} * {64'b0, xsq};
        q    = prod >> (2 * FRAC_BITS);
        if (q[127:64] != 64'b0) q = {64'b0, {64{1'b1}}};
        q = q / k;
        if (q > {64'b0, TERM_LIMIT}) begin
          q   = {64'b0, TERM_LIMIT};
          sat = 1'b1;
        end
        mag = q[63:0];
        neg = !neg;
      end
      o.cosine        = sum[COS_W-1:0];
      o.terms_used    = used[COUNT_W-1:0];
      o.not_converged = nconv;
      o.saturated     = sat;
      return o;
    endfunction

    function void note_request(tcu_req_t r);
      expected_q.push_back(cosine_of(r));
    endfunction

    function void check_result(tcu_rsp_t got);
      tcu_rsp_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: cosine %0d", got.cosine);
        fault_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.cosine !== want.cosine) begin
        $error("cosine: expected %0d, actual %0d", want.cosine, got.cosine);
        fault_count++;
      end
      if (got.terms_used !== want.terms_used) begin
        $error("terms_used: expected %0d, actual %0d", want.terms_used, got.terms_used);
        fault_count++;
      end
      if (got.not_converged !== want.not_converged) begin
        $error("not_converged: expected %0b, actual %0b", want.not_converged,
               got.not_converged);
        fault_count++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
        fault_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  tcu_req_t req_i  = '0;
  logic     done_o;
  tcu_rsp_t rsp_o;

  cosine_scoreboard sb = new();
  int unsigned      cycle_count = 0;

  taylor_cosine_unit #(
    .MAX_TERMS(MAX_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_request(req_i);
      if (done_o) sb.check_result(rsp_o);
    end
  end

  task automatic drive_request(input logic cmd, input logic [31:0] ang,
                               input logic [4:0] cnt, input logic [30:0] tol);
    tcu_req_t r;
    r.command    = cmd;
    r.angle      = ang;
    r.term_count = cnt;
    r.tolerance  = tol;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drive_random_request();
    logic        cmd;
    logic [31:0] ang;
    logic [4:0]  cnt;
    logic [30:0] tol;
    int unsigned pick;
    cmd  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 3);
    if (pick == 0) ang = $urandom;
    else if (pick == 1) ang = 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
    else ang = 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
    cnt  = 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 3);
    if (pick == 0) tol = 31'($urandom);
    else if (pick == 3) tol = 31'($urandom_range(0, 3));
    else tol = 31'($urandom) >> $urandom_range(0, 30);
    drive_request(cmd, ang, cnt, tol);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_request(CMD_FIXED, 32'h0000_0000, 5'd0,  31'd0);
    drive_request(CMD_FIXED, 32'h1000_0000, 5'd0,  31'h7FFF_FFFF);
    drive_request(CMD_FIXED, 32'h1000_0000, 5'd1,  31'd0);
    drive_request(CMD_FIXED, 32'h1000_0000, 5'd16, 31'd0);
    drive_request(CMD_FIXED, 32'h1000_0000, 5'd17, 31'd0);
    drive_request(CMD_FIXED, 32'h1000_0000, 5'd31, 31'd0);
    drive_request(CMD_FIXED, 32'h7FFF_FFFF, 5'd16, 31'd0);
    drive_request(CMD_FIXED, 32'h8000_0000, 5'd16, 31'd0);
    drive_request(CMD_FIXED, 32'h8000_0001, 5'd31, 31'd0);
    drive_request(CMD_FIXED, 32'hFFFF_FFFF, 5'd3,  31'd0);
    drive_request(CMD_FIXED, 32'h0000_0001, 5'd2,  31'd0);
    drive_request(CMD_FIXED, 32'h3243_F6A8, 5'd10, 31'd0);
    drive_request(CMD_TOL,   32'h0000_0000, 5'd0,  31'd0);
    drive_request(CMD_TOL,   32'h1000_0000, 5'd0,  31'd0);
    drive_request(CMD_TOL,   32'h1000_0000, 5'd0,  31'd1);
    drive_request(CMD_TOL,   32'h1000_0000, 5'd0,  31'h7FFF_FFFF);
    drive_request(CMD_TOL,   32'h1000_0000, 5'd0,  31'h1000_0000);
    drive_request(CMD_TOL,   32'h7FFF_FFFF, 5'd31, 31'd0);
    drive_request(CMD_TOL,   32'h8000_0000, 5'd0,  31'h0000_1000);
    drive_request(CMD_TOL,   32'h3243_F6A8, 5'd0,  31'h0000_0100);
    drive_request(CMD_TOL,   32'hCDBC_0958, 5'd5,  31'h0001_0000);
    drive_request(CMD_TOL,   32'h0000_0001, 5'd0,  31'd0);

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        drive_random_request();
        sent++;
      end
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tcu_pkg.sv
rtl/taylor_cosine_unit.sv
dv/taylor_cosine_unit_test.sv
